@@ rtl/irct_pkg.sv @@
// ----------------------------------------------------------------------------
// irct_pkg
// Shared constants and types of the index range coalescing table.
// ----------------------------------------------------------------------------
`default_nettype none

package irct_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int INDEX_BITS_DEF  = 24;
	// byte offset = index * 4
	localparam int BYTE_SHIFT      = 2;

	// Append status codes
	localparam logic [2:0] ST_IGNORED  = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_EXTENDED = 3'd2;
	localparam logic [2:0] ST_MERGED   = 3'd3;
	localparam logic [2:0] ST_INSERTED = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	// Datapath action codes
	localparam logic [3:0] DP_NONE      = 4'd0;
	localparam logic [3:0] DP_LOAD      = 4'd1;
	localparam logic [3:0] DP_RD_IDX    = 4'd2;
	localparam logic [3:0] DP_RD_NEXT   = 4'd3;
	localparam logic [3:0] DP_RD_PREV   = 4'd4;
	localparam logic [3:0] DP_SCAN_STEP = 4'd5;
	localparam logic [3:0] DP_EXT_WR    = 4'd6;
	localparam logic [3:0] DP_MERGE_WR  = 4'd7;
	localparam logic [3:0] DP_SHL_WR    = 4'd8;
	localparam logic [3:0] DP_INS_START = 4'd9;
	localparam logic [3:0] DP_INS_WR    = 4'd10;
	localparam logic [3:0] DP_INS_FINAL = 4'd11;
	localparam logic [3:0] DP_DEC       = 4'd12;
	localparam logic [3:0] DP_CLR       = 4'd13;
	localparam logic [3:0] DP_INC_IDX   = 4'd14;

	// Command from controller to datapath
	typedef struct packed {
		logic [3:0] act;
		logic       emit;
		logic       kind;
		logic       entry;   // emit the registered table entry
		logic [2:0] status;
		logic       last;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic op;
		logic n_zero;
		logic cnt_zero;
		logic cnt_full;
		logic idx_eq_cnt;
		logic idx_eq_pos;
		logic next_lt_cnt;
		logic last_entry;
		logic ovf;
		logic contains;
		logic end_hit;
		logic merge_hit;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/irct_datapath.sv @@
// ----------------------------------------------------------------------------
// irct_datapath
// Range table memory, pointers, compare logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irct_datapath #(
	parameter int TABLE_DEPTH = irct_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_BITS  = irct_pkg::INDEX_BITS_DEF,
	localparam int CW = $clog2(TABLE_DEPTH + 1),
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int SW = INDEX_BITS + irct_pkg::BYTE_SHIFT,
	localparam int LW = INDEX_BITS + 1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire irct_pkg::ctl_t   ctl,
	output irct_pkg::sts_t        sts,
	input  wire                   in_op,
	input  wire  [INDEX_BITS-1:0] in_start,
	input  wire  [INDEX_BITS-1:0] in_length,
	input  wire                   cfg_valid,
	input  wire                   cfg_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic                  out_kind,
	output logic [2:0]            out_status,
	output logic [SW-1:0]         out_start,
	output logic [LW-1:0]         out_length,
	output logic                  out_last
);

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [INDEX_BITS+LW-1:0] mem [TABLE_DEPTH];

	logic                  mode_q;
	logic                  op_q;
	logic [INDEX_BITS-1:0] s_q, n_q, ext_st_q, rd_st_q;
	logic [LW-1:0]         acc_q, rd_len_q;
	logic [CW-1:0]         idx_q, cnt_q, pos_q;
	logic                  pos_set_q;
	logic                  out_valid_q;

	logic [LW-1:0] sum_sn, rd_end, ext_len, mrg_len;
	logic [CW:0]   idx_p1;
	logic [AW-1:0] idx_a, next_a, prev_a;
	logic [SW-1:0] drain_start;
	logic          out_free;

	// Compare and address logic
	assign sum_sn  = {1'b0, s_q} + {1'b0, n_q};
	assign rd_end  = {1'b0, rd_st_q} + rd_len_q;
	assign ext_len = rd_len_q + {1'b0, n_q};
	assign mrg_len = acc_q + rd_len_q;
	assign idx_p1  = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_a   = idx_q[AW-1:0];
	assign next_a  = idx_a + AW'(1);
	assign prev_a  = idx_a - AW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign drain_start = mode_q ? {rd_st_q, {irct_pkg::BYTE_SHIFT{1'b0}}} : SW'(rd_st_q);

	always_comb begin
		sts.op          = op_q;
		sts.n_zero      = (n_q == '0);
		sts.cnt_zero    = (cnt_q == '0);
		sts.cnt_full    = (cnt_q == DEPTH_C);
		sts.idx_eq_cnt  = (idx_q == cnt_q);
		sts.idx_eq_pos  = (idx_q == pos_q);
		sts.next_lt_cnt = (idx_p1 < {1'b0, cnt_q});
		sts.last_entry  = (idx_p1 == {1'b0, cnt_q});
		sts.ovf         = sum_sn[INDEX_BITS] && (sum_sn[INDEX_BITS-1:0] != '0);
		sts.contains    = (rd_st_q <= s_q) && ({1'b0, s_q} < rd_end);
		sts.end_hit     = (rd_end == {1'b0, s_q});
		sts.merge_hit   = (sum_sn == {1'b0, rd_st_q});
		sts.out_free    = out_free;
	end

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// Table memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		case (ctl.act)
			irct_pkg::DP_EXT_WR:    mem[idx_a] <= {rd_st_q, ext_len};
			irct_pkg::DP_MERGE_WR:  mem[idx_a] <= {ext_st_q, mrg_len};
			irct_pkg::DP_SHL_WR,
			irct_pkg::DP_INS_WR:    mem[idx_a] <= {rd_st_q, rd_len_q};
			irct_pkg::DP_INS_FINAL: mem[idx_a] <= {s_q, 1'b0, n_q};
			default: ;
		endcase
		case (ctl.act)
			irct_pkg::DP_RD_IDX:  {rd_st_q, rd_len_q} <= mem[idx_a];
			irct_pkg::DP_RD_NEXT: {rd_st_q, rd_len_q} <= mem[next_a];
			irct_pkg::DP_RD_PREV: {rd_st_q, rd_len_q} <= mem[prev_a];
			default: ;
		endcase
	end

	// Capture the transaction and hold work registers
	always_ff @(posedge clk) begin
		case (ctl.act)
			irct_pkg::DP_LOAD: begin
				op_q <= in_op;
				s_q  <= in_start;
				n_q  <= in_length;
			end
			irct_pkg::DP_EXT_WR: begin
				acc_q    <= ext_len;
				ext_st_q <= rd_st_q;
			end
			default: ;
		endcase
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			pos_set_q <= 1'b0;
		end else begin
			case (ctl.act)
				irct_pkg::DP_LOAD: begin
					idx_q     <= '0;
					pos_q     <= cnt_q;
					pos_set_q <= 1'b0;
				end
				irct_pkg::DP_SCAN_STEP: begin
					if (!pos_set_q && rd_st_q >= s_q) begin
						pos_q     <= idx_q;
						pos_set_q <= 1'b1;
					end
					idx_q <= idx_p1[CW-1:0];
				end
				irct_pkg::DP_MERGE_WR,
				irct_pkg::DP_SHL_WR,
				irct_pkg::DP_INC_IDX:   idx_q <= idx_p1[CW-1:0];
				irct_pkg::DP_INS_START: idx_q <= cnt_q;
				irct_pkg::DP_INS_WR:    idx_q <= idx_q - CW'(1);
				irct_pkg::DP_INS_FINAL: cnt_q <= cnt_q + CW'(1);
				irct_pkg::DP_DEC:       cnt_q <= cnt_q - CW'(1);
				irct_pkg::DP_CLR:       cnt_q <= '0;
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && out_free) begin
			out_kind   <= ctl.kind;
			out_status <= ctl.status;
			out_start  <= ctl.entry ? drain_start : '0;
			out_length <= ctl.entry ? rd_len_q : '0;
			out_last   <= ctl.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/irct_controller.sv @@
// ----------------------------------------------------------------------------
// irct_controller
// Sequencer for append scan, extend/merge, insert shift and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module irct_controller (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire irct_pkg::sts_t sts,
	output irct_pkg::ctl_t      ctl
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_SCAN_RD = 4'd2;
	localparam logic [3:0] S_SCAN_EV = 4'd3;
	localparam logic [3:0] S_EXT_RD  = 4'd4;
	localparam logic [3:0] S_EXT_EV  = 4'd5;
	localparam logic [3:0] S_SHL_RD  = 4'd6;
	localparam logic [3:0] S_SHL_EV  = 4'd7;
	localparam logic [3:0] S_INS_RD  = 4'd8;
	localparam logic [3:0] S_INS_EV  = 4'd9;
	localparam logic [3:0] S_DR_RD   = 4'd10;
	localparam logic [3:0] S_DR_EV   = 4'd11;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath command
	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		ctl.act    = irct_pkg::DP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.act = irct_pkg::DP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.op) begin
					if (!sts.cnt_zero) begin
						state_d = S_DR_RD;
					end else if (sts.out_free) begin
						ctl.emit = 1'b1;
						ctl.kind = 1'b1;
						ctl.last = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (!sts.n_zero) begin
					state_d = S_SCAN_RD;
				end else if (sts.out_free) begin
					ctl.emit   = 1'b1;
					ctl.status = irct_pkg::ST_IGNORED;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				if (!sts.idx_eq_cnt) begin
					ctl.act = irct_pkg::DP_RD_IDX;
					state_d = S_SCAN_EV;
				end else if (!sts.ovf && !sts.cnt_full) begin
					ctl.act = irct_pkg::DP_INS_START;
					state_d = S_INS_RD;
				end else if (sts.out_free) begin
					ctl.emit   = 1'b1;
					ctl.status = sts.ovf ? irct_pkg::ST_OVERFLOW : irct_pkg::ST_FULL;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN_EV: begin
				if (sts.contains || (sts.end_hit && sts.ovf)) begin
					if (sts.out_free) begin
						ctl.emit   = 1'b1;
						ctl.status = sts.contains ? irct_pkg::ST_PRESENT
						                          : irct_pkg::ST_OVERFLOW;
						ctl.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end else if (sts.end_hit) begin
					ctl.act = irct_pkg::DP_EXT_WR;
					state_d = S_EXT_RD;
				end else begin
					ctl.act = irct_pkg::DP_SCAN_STEP;
					state_d = S_SCAN_RD;
				end
			end
			S_EXT_RD: begin
				if (sts.next_lt_cnt) begin
					ctl.act = irct_pkg::DP_RD_NEXT;
					state_d = S_EXT_EV;
				end else if (sts.out_free) begin
					ctl.emit   = 1'b1;
					ctl.status = irct_pkg::ST_EXTENDED;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_EXT_EV: begin
				if (sts.merge_hit) begin
					ctl.act = irct_pkg::DP_MERGE_WR;
					state_d = S_SHL_RD;
				end else if (sts.out_free) begin
					ctl.emit   = 1'b1;
					ctl.status = irct_pkg::ST_EXTENDED;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			// Close the gap left by the absorbed range
			S_SHL_RD: begin
				if (sts.next_lt_cnt) begin
					ctl.act = irct_pkg::DP_RD_NEXT;
					state_d = S_SHL_EV;
				end else if (sts.out_free) begin
					ctl.act    = irct_pkg::DP_DEC;
					ctl.emit   = 1'b1;
					ctl.status = irct_pkg::ST_MERGED;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SHL_EV: begin
				ctl.act = irct_pkg::DP_SHL_WR;
				state_d = S_SHL_RD;
			end
			// Open a slot at the insert position, top entry first
			S_INS_RD: begin
				if (!sts.idx_eq_pos) begin
					ctl.act = irct_pkg::DP_RD_PREV;
					state_d = S_INS_EV;
				end else if (sts.out_free) begin
					ctl.act    = irct_pkg::DP_INS_FINAL;
					ctl.emit   = 1'b1;
					ctl.status = irct_pkg::ST_INSERTED;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_INS_EV: begin
				ctl.act = irct_pkg::DP_INS_WR;
				state_d = S_INS_RD;
			end
			S_DR_RD: begin
				ctl.act = irct_pkg::DP_RD_IDX;
				state_d = S_DR_EV;
			end
			S_DR_EV: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					ctl.kind  = 1'b1;
					ctl.entry = 1'b1;
					ctl.last  = sts.last_entry;
					if (sts.last_entry) begin
						ctl.act = irct_pkg::DP_CLR;
						state_d = S_IDLE;
					end else begin
						ctl.act = irct_pkg::DP_INC_IDX;
						state_d = S_DR_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/index_range_coalescing_table.sv @@
// ----------------------------------------------------------------------------
// index_range_coalescing_table
// Sorted table of index ranges with append, coalesce and drain.
// ----------------------------------------------------------------------------
// One transaction at a time. The table sits in a single-port memory with a
// registered read, so each stored range visited takes a read state and an
// evaluate state. An append scans the ranges in order and moves entries
// when a range is inserted or two ranges merge; a drain gives one result
// per range. Results wait in an output register; the user must write
// byte_offset_mode (cfg_data) only while idle, not enforced by the block.
`default_nettype none

module index_range_coalescing_table #(
	parameter int TABLE_DEPTH = irct_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_BITS  = irct_pkg::INDEX_BITS_DEF,
	localparam int IN_DW  = ((2 * INDEX_BITS + 7) / 8) * 8,
	localparam int SW     = INDEX_BITS + irct_pkg::BYTE_SHIFT,
	localparam int LW     = INDEX_BITS + 1,
	localparam int OUT_DW = ((3 + SW + LW + 7) / 8) * 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [IN_DW-1:0]  s_tdata,   // range_start, range_length
	input  wire               s_tuser,   // operation
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // status, entry_start, entry_length
	output logic              m_tuser,   // kind
	output logic              m_tlast,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_data   // byte_offset_mode
);

	irct_pkg::ctl_t ctl;
	irct_pkg::sts_t sts;
	logic [2:0]    out_status;
	logic [SW-1:0] out_start;
	logic [LW-1:0] out_length;

	assign cfg_ready = 1'b1;

	irct_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	irct_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.INDEX_BITS  (INDEX_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_start   (s_tdata[INDEX_BITS-1:0]),
		.in_length  (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_status (out_status),
		.out_start  (out_start),
		.out_length (out_length),
		.out_last   (m_tlast)
	);

	// Pack the result fields, zero fill to whole bytes
	assign m_tdata = OUT_DW'({out_length, out_start, out_status});

endmodule

`default_nettype wire

@@ rtl/irct_checker.sv @@
// ----------------------------------------------------------------------------
// irct_checker
// Port level checks of the index range coalescing table.
// ----------------------------------------------------------------------------
`default_nettype none

module irct_checker #(
	parameter int INDEX_BITS  = irct_pkg::INDEX_BITS_DEF,
	localparam int SW     = INDEX_BITS + irct_pkg::BYTE_SHIFT,
	localparam int OUT_DW = ((3 + SW + INDEX_BITS + 1 + 7) / 8) * 8
) (
	input wire              clk,
	input wire              arst_n,
	input wire              s_tvalid,
	input wire              s_tready,
	input wire              m_tvalid,
	input wire              m_tready,
	input wire [OUT_DW-1:0] m_tdata,
	input wire              m_tuser,
	input wire              m_tlast
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Every append status ends its transaction
	a_app_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("append status without last");

	// Drained entries carry no status
	a_drain_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == irct_pkg::ST_IGNORED)
		else $error("drained entry with status");

	// Status code stays in its defined set
	a_st_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("undefined status code");

	// No new input while busy with a transaction just taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

endmodule

bind index_range_coalescing_table irct_checker #(
	.INDEX_BITS  (INDEX_BITS)
) u_irct_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the index range coalescing table: directed and
// random append/drain traffic with random idling on both streams, every
// output transaction checked in order against a behavioral model of the
// sorted range table.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH    = 32;
	localparam int IB       = 24;
	localparam int IN_DW    = 48;
	localparam int OUT_DW   = 56;
	localparam int WDOG_MAX = 20000;
	localparam int N_RAND   = 150;
	localparam int N_DIR    = 17;
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [25:0] start;
		logic [24:0] length;
		logic        last;
	} range_result_t;

	typedef struct {
		logic        op;
		logic [23:0] start;
		logic [23:0] length;
		logic        chk;
		logic [2:0]  status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	index_range_coalescing_table i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic [23:0] tbl_start [DEPTH];
	logic [24:0] tbl_len [DEPTH];
	int          tbl_count = 0;
	logic        byte_mode = 1'b0;

	range_result_t expected_q[$];
	int  mismatches = 0;
	int  wdog = 0;
	bit  idle_en = 1'b0;

	task automatic report(input string what, input range_result_t got, input range_result_t exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		mismatches++;
	endtask

	// Append one expected result at the tail of the queue.
	task automatic queue_expected(input range_result_t r);
		expected_q.insert(expected_q.size(), r);
	endtask

	function automatic logic [2:0] apply_append(input logic [23:0] s, input logic [23:0] n);
		logic [24:0] lim;
		logic [25:0] e;
		logic [24:0] fin;
		int pos;
		lim = 25'h1000000;
		fin = {1'b0, s} + {1'b0, n};
		if (n == 0) return irct_pkg::ST_IGNORED;
		// scan in ascending order; first hit decides
		for (int i = 0; i < tbl_count; i++) begin
			e = {2'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
			if (tbl_start[i] <= s && {2'b0, s} < e) return irct_pkg::ST_PRESENT;
			if (e == {2'b0, s}) begin
				if (fin > lim) return irct_pkg::ST_OVERFLOW;
				tbl_len[i] = tbl_len[i] + {1'b0, n};
				if (i + 1 < tbl_count && fin == {1'b0, tbl_start[i+1]}) begin
					tbl_len[i] = tbl_len[i] + tbl_len[i+1];
					for (int j = i + 1; j + 1 < tbl_count; j++) begin
						tbl_start[j] = tbl_start[j+1];
						tbl_len[j] = tbl_len[j+1];
					end
					tbl_count--;
					return irct_pkg::ST_MERGED;
				end
				return irct_pkg::ST_EXTENDED;
			end
		end
		if (fin > lim) return irct_pkg::ST_OVERFLOW;
		if (tbl_count >= DEPTH) return irct_pkg::ST_FULL;
		pos = 0;
		while (pos < tbl_count && tbl_start[pos] < s) pos++;
		for (int i = tbl_count; i > pos; i--) begin
			tbl_start[i] = tbl_start[i-1];
			tbl_len[i] = tbl_len[i-1];
		end
		tbl_start[pos] = s;
		tbl_len[pos] = {1'b0, n};
		tbl_count++;
		return irct_pkg::ST_INSERTED;
	endfunction

	// Compute expected results of one item and queue them.
	task automatic predict_ranges(input logic op, input logic [23:0] s, input logic [23:0] n,
		input logic chk, input logic [2:0] typed);
		range_result_t r;
		r = '0;
		if (op == OP_APPEND) begin
			r.kind = KIND_STATUS;
			r.status = apply_append(s, n);
			r.last = 1'b1;
			if (chk && r.status != typed)
				$display("table row status %0d disagrees with model %0d", typed, r.status);
			if (chk) r.status = typed;
			queue_expected(r);
		end else if (tbl_count == 0) begin
			r.kind = KIND_ENTRY;
			r.last = 1'b1;
			queue_expected(r);
		end else begin
			for (int i = 0; i < tbl_count; i++) begin
				r.kind = KIND_ENTRY;
				r.status = irct_pkg::ST_IGNORED;
				r.start = byte_mode ? {tbl_start[i], 2'b00} : {2'b00, tbl_start[i]};
				r.length = tbl_len[i];
				r.last = (i + 1 == tbl_count);
				queue_expected(r);
			end
			tbl_count = 0;
		end
	endtask

	// Drive one transaction; valid drops only while idling or between phases.
	task automatic send_item(input logic op, input logic [23:0] s, input logic [23:0] n,
		input logic chk, input logic [2:0] typed);
		while (idle_en && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {n, s};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_ranges(op, s, n, chk, typed);
		@(negedge clk);
	endtask

	task automatic write_mode(input logic v);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		byte_mode = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pick an append that tends to hit, extend or merge the stored ranges.
	task automatic random_append();
		logic [23:0] s, n;
		int k;
		k = $urandom_range(9);
		s = 24'($urandom_range(4000));
		n = 24'($urandom_range(1, 40));
		if (tbl_count > 0 && k < 6) begin
			int i;
			i = $urandom_range(tbl_count - 1);
			case (k)
				0, 1: s = 24'(tbl_start[i] + tbl_len[i]);
				2: begin
					s = 24'(tbl_start[i] + tbl_len[i]);
					if (i + 1 < tbl_count && tbl_start[i+1] > s) n = tbl_start[i+1] - s;
				end
				3: s = 24'(tbl_start[i] + $urandom_range(tbl_len[i] - 1));
				default: ;
			endcase
		end else if (k == 9) begin
			s = 24'($urandom);
			n = 24'($urandom);
			if ($urandom_range(3) == 0) n = '0;
		end
		send_item(OP_APPEND, s, n, 1'b0, irct_pkg::ST_IGNORED);
	endtask

	// Check output transactions in order.
	always @(posedge clk) begin
		range_result_t got, exp;
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.status = m_tdata[2:0];
			got.start = m_tdata[28:3];
			got.length = m_tdata[53:29];
			got.last = m_tlast;
			if (expected_q.size() == 0) begin
				report("unexpected", got, '0);
			end else begin
				exp = expected_q.pop_front();
				if (got.kind != exp.kind) report("kind", got, exp);
				if (got.status != exp.status) report("status", got, exp);
				if (got.start != exp.start) report("entry_start", got, exp);
				if (got.length != exp.length) report("entry_length", got, exp);
				if (got.last != exp.last) report("last", got, exp);
				if (m_tdata[OUT_DW-1:54] != 0) report("pad", got, exp);
			end
		end
	end

	// Stall the result stream.
	always @(negedge clk) begin
		m_tready <= idle_en ? ($urandom_range(99) >= 24) : 1'b1;
	end

	// Watchdog on transactions.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog > WDOG_MAX) begin
			$display("tb: failure");
			$finish;
		end
	end

	stim_row_t dir_rows [N_DIR] = '{
		'{OP_DRAIN,  24'd0,       24'd0,       1'b0, irct_pkg::ST_IGNORED},
		'{OP_APPEND, 24'd5,       24'd0,       1'b1, irct_pkg::ST_IGNORED},
		'{OP_APPEND, 24'd100,     24'd10,      1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'd105,     24'd3,       1'b1, irct_pkg::ST_PRESENT},
		'{OP_APPEND, 24'd110,     24'd5,       1'b1, irct_pkg::ST_EXTENDED},
		'{OP_APPEND, 24'd120,     24'd4,       1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'd115,     24'd5,       1'b1, irct_pkg::ST_MERGED},
		'{OP_APPEND, 24'd50,      24'd80,      1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'd0,       24'd1,       1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'hFFFFFF,  24'd2,       1'b1, irct_pkg::ST_OVERFLOW},
		'{OP_APPEND, 24'hFFFFFF,  24'd1,       1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'h800000,  24'hFFFFFF,  1'b1, irct_pkg::ST_OVERFLOW},
		'{OP_APPEND, 24'h000001,  24'hFFFFFE,  1'b1, irct_pkg::ST_EXTENDED},
		'{OP_DRAIN,  24'hFFFFFF,  24'hFFFFFF,  1'b0, irct_pkg::ST_IGNORED},
		'{OP_APPEND, 24'd0,       24'hFFFFFF,  1'b1, irct_pkg::ST_INSERTED},
		'{OP_APPEND, 24'hFFFFFF,  24'd1,       1'b1, irct_pkg::ST_EXTENDED},
		'{OP_DRAIN,  24'd0,       24'd0,       1'b0, irct_pkg::ST_IGNORED}
	};

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].start, dir_rows[i].length,
				dir_rows[i].chk, dir_rows[i].status);

		// fill past capacity, then drain in byte offset mode
		write_mode(1'b1);
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(OP_APPEND, 24'(i * 10 + 3), 24'd2, 1'b1,
				i < DEPTH ? irct_pkg::ST_INSERTED : irct_pkg::ST_FULL);
		send_item(OP_DRAIN, 24'd0, 24'd0, 1'b0, irct_pkg::ST_IGNORED);
		send_item(OP_APPEND, 24'hFFFFFF, 24'd1, 1'b1, irct_pkg::ST_INSERTED);
		send_item(OP_DRAIN, 24'd0, 24'd0, 1'b0, irct_pkg::ST_IGNORED);

		// random phases, alternating mode, with a quiet stretch
		for (int ph = 0; ph < 3; ph++) begin
			write_mode(ph[0]);
			idle_en = (ph != 1);
			for (int i = 0; i < N_RAND / 3; i++) begin
				if ($urandom_range(19) == 0)
					send_item(OP_DRAIN, 24'($urandom), 24'($urandom), 1'b0,
						irct_pkg::ST_IGNORED);
				else
					random_append();
			end
			send_item(OP_DRAIN, 24'd0, 24'd0, 1'b0, irct_pkg::ST_IGNORED);
		end

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
